FILE: hdl/top_k_sorted_insert_macros.svh
// ----------------------------------------------------------------------------
// top_k_sorted_insert assertion macros
// Shared concurrent assertion forms for the ranked list block.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SORTED_INSERT_MACROS_SVH
`define TOP_K_SORTED_INSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TKS_ASSERT_IMP(name, clk_i, rstn_i, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define TKS_ASSERT_NXT(name, clk_i, rstn_i, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg
// Types, codes and helpers shared by the ranked list cells and controller.
// ----------------------------------------------------------------------------
package tks_pkg;

	localparam int MAX_KEEP_DEF = 16;
	localparam int KEEP_W       = 5;
	localparam logic [KEEP_W-1:0] KEEP_RST = 5'd16;
	localparam int IN_DATA_W    = 64;
	localparam int OUT_DATA_W   = 72;
	localparam int POS_W        = 4;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DUMP   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_ENTRY  = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

	typedef struct packed {
		logic [15:0]        node_a;
		logic [15:0]        node_b;
		logic signed [31:0] score;
	} entry_t;

	// per-cycle command to every cell of the chain
	typedef struct packed {
		logic insert;
		logic rotate;
	} chain_ctrl_t;

	typedef struct packed {
		kind_t              kind;
		logic               accepted;
		logic [POS_W-1:0]   position;
		logic               entry_valid;
		entry_t             entry;
		logic               last;
	} result_t;

	// keep count clamped to 1..max_keep
	function automatic int eff_keep(logic [KEEP_W-1:0] v, int max_keep);
		int r;
		r = int'(v);
		if (r < 1) r = 1;
		if (r > max_keep) r = max_keep;
		return r;
	endfunction

endpackage

FILE: hdl/top_k_sorted_insert.sv
// Insert, clear and empty-dump results are registered and appear in the cycle after the
// input beat; the first entry beat of a non-empty dump follows the move to the dump state
// and waits for a free output register. Insert and clear commands are accepted back to
// back while the output is free. During a dump, entries leave the head cell while the cell
// chain rotates once per beat. One item is in work at a time.
// Reset (arst_n low): list empty, keep count 16, no result pending.
// ----------------------------------------------------------------------------
// top_k_sorted_insert
// Keeps the best scored node pairs sorted by descending Q16.16 score in a
// chain of shift-insert cells; supports insert, dump and clear commands.
// ----------------------------------------------------------------------------
`include "top_k_sorted_insert_macros.svh"

module top_k_sorted_insert #(
	parameter int MAX_KEEP = tks_pkg::MAX_KEEP_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tks_pkg::KEEP_W-1:0]       cfg_wdata,     // keep_count
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [tks_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // node_a, node_b, score
	input  logic [1:0]                       s_axis_tuser,  // op
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// accepted, position, entry_valid, out_node_a, out_node_b, out_score, pad
	output logic [tks_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic [1:0]                       m_axis_tuser,  // kind
	output logic                             m_axis_tlast
);
	import tks_pkg::*;

	localparam int CW = $clog2(MAX_KEEP + 1);
	localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

	state_t            state_q, state_d;
	logic [KEEP_W-1:0] keep_q;
	logic [CW-1:0]     held_q, held_d, held_n;
	logic [IW-1:0]     idx_q, idx_d;
	result_t           out_q, res_d;
	logic              out_valid_q;
	logic              out_load;

	op_t               op;
	entry_t            in_entry;
	logic [CW-1:0]     eff_w, eff_cfg_w;
	logic              ofree, in_fire, dump_last;
	chain_ctrl_t       ctrl;
	entry_t            head;
	logic [IW-1:0]     pos;
	logic              reject;
	logic [IW+3:0]     pos_w, idx_w;

	// input beat unpack
	assign op              = op_t'(s_axis_tuser);
	assign in_entry.node_a = s_axis_tdata[15:0];
	assign in_entry.node_b = s_axis_tdata[31:16];
	assign in_entry.score  = signed'(s_axis_tdata[63:32]);

	assign eff_w     = CW'(eff_keep(keep_q, MAX_KEEP));
	assign eff_cfg_w = CW'(eff_keep(cfg_wdata, MAX_KEEP));
	assign ofree     = !out_valid_q || m_axis_tready;
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign dump_last = ((CW'(idx_q) + CW'(1)) == held_q);
	assign pos_w     = {4'b0, pos};
	assign idx_w     = {4'b0, idx_q};

	tks_chain #(
		.MAX_KEEP(MAX_KEEP),
		.CW      (CW),
		.IW      (IW)
	) u_chain (
		.clk      (clk),
		.ctrl     (ctrl),
		.new_entry(in_entry),
		.held     (held_q),
		.keep     (eff_w),
		.head     (head),
		.pos      (pos),
		.reject   (reject)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && (op == OP_DUMP) && (held_q != '0)) state_d = ST_DUMP;
			end
			ST_DUMP: begin
				if (ofree && dump_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// controller outputs and datapath updates
	always_comb begin
		s_axis_tready = 1'b0;
		ctrl          = '0;
		out_load      = 1'b0;
		res_d         = '0;
		held_d        = held_q;
		idx_d         = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = ofree;
				if (in_fire) begin
					unique case (op)
						OP_INSERT: begin
							out_load   = 1'b1;
							res_d.kind = KIND_INSERT;
							res_d.last = 1'b1;
							if (!reject) begin
								ctrl.insert    = 1'b1;
								res_d.accepted = 1'b1;
								res_d.position = pos_w[3:0];
								if (held_q < eff_w) held_d = held_q + CW'(1);
							end
						end
						OP_DUMP: begin
							if (held_q == '0) begin
								out_load   = 1'b1;
								res_d.kind = KIND_ENTRY;
								res_d.last = 1'b1;
							end else begin
								idx_d = '0;
							end
						end
						OP_CLEAR: begin
							out_load   = 1'b1;
							res_d.kind = KIND_CLEAR;
							res_d.last = 1'b1;
							held_d     = '0;
						end
						default: ;
					endcase
				end
			end
			ST_DUMP: begin
				if (ofree) begin
					out_load          = 1'b1;
					ctrl.rotate       = 1'b1;
					res_d.kind        = KIND_ENTRY;
					res_d.entry_valid = 1'b1;
					res_d.position    = idx_w[3:0];
					res_d.entry       = head;
					res_d.last        = dump_last;
					idx_d             = idx_q + IW'(1);
				end
			end
			default: ;
		endcase
	end

	// a lowered keep count trims the list
	assign held_n = cfg_we ? ((held_q > eff_cfg_w) ? eff_cfg_w : held_q) : held_d;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			keep_q      <= KEEP_RST;
			held_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			held_q  <= held_n;
			idx_q   <= idx_d;
			if (cfg_we) keep_q <= cfg_wdata;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (out_load) out_q <= res_d;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_q.last;
	assign m_axis_tdata  = {2'b00, out_q.entry.score, out_q.entry.node_b,
		out_q.entry.node_a, out_q.entry_valid, out_q.position, out_q.accepted};

	`TKS_ASSERT_IMP(a_held_bound, clk, arst_n, 1'b1, held_q <= eff_w, "held count above keep count")
	`TKS_ASSERT_IMP(a_busy_dump, clk, arst_n, state_q == ST_DUMP, !s_axis_tready, "input taken mid-dump")
	`TKS_ASSERT_IMP(a_dump_idx, clk, arst_n, state_q == ST_DUMP, CW'(idx_q) < held_q, "dump rank past list end")
	`TKS_ASSERT_NXT(a_held_step, clk, arst_n, in_fire && (op == OP_INSERT), {1'b0, held_q} <= ({1'b0, $past(held_q)} + 1'b1), "insert grew list by more than one")

endmodule

FILE: hdl/tks_cell.sv
// ----------------------------------------------------------------------------
// tks_cell
// One rank of the sorted list: holds an entry, compares it with the
// incoming score and shifts, loads or rotates as the chain commands.
// ----------------------------------------------------------------------------
module tks_cell (
	input  logic                 clk,
	input  tks_pkg::chain_ctrl_t ctrl,
	input  tks_pkg::entry_t      new_entry,
	input  tks_pkg::entry_t      left_entry,
	input  tks_pkg::entry_t      right_entry,
	input  logic                 occupied,
	input  logic                 ge_left,
	output logic                 ge,
	output tks_pkg::entry_t      entry
);
	import tks_pkg::*;

	entry_t entry_q;

	// held entry ranks at or above the candidate
	assign ge    = occupied && (new_entry.score <= entry_q.score);
	assign entry = entry_q;

	// insert: keep, take the candidate, or shift down from the left
	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (!ge) begin
				entry_q <= ge_left ? new_entry : left_entry;
			end
		end else if (ctrl.rotate) begin
			entry_q <= right_entry;
		end
	end

endmodule

FILE: hdl/tks_chain.sv
// ----------------------------------------------------------------------------
// tks_chain
// Row of ranked cells with insert position and reject decision.
// ----------------------------------------------------------------------------
module tks_chain #(
	parameter int MAX_KEEP = tks_pkg::MAX_KEEP_DEF,
	parameter int CW       = $clog2(MAX_KEEP + 1),
	parameter int IW       = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1
) (
	input  logic                 clk,
	input  tks_pkg::chain_ctrl_t ctrl,
	input  tks_pkg::entry_t      new_entry,
	input  logic [CW-1:0]        held,
	input  logic [CW-1:0]        keep,
	output tks_pkg::entry_t      head,
	output logic [IW-1:0]        pos,
	output logic                 reject
);
	import tks_pkg::*;

	entry_t               ents [MAX_KEEP];
	logic [MAX_KEEP-1:0]  ge;
	logic                 all_ge;

	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
		entry_t left_w;
		entry_t right_w;
		logic   ge_left_w;

		if (i == 0) begin : g_first
			assign left_w    = new_entry;
			assign ge_left_w = 1'b1;
		end else begin : g_mid
			assign left_w    = ents[i-1];
			assign ge_left_w = ge[i-1];
		end

		// last held rank wraps to the head during a dump
		if (i == MAX_KEEP - 1) begin : g_end
			assign right_w = ents[0];
		end else begin : g_inner
			assign right_w = (CW'(i + 1) == held) ? ents[0] : ents[i+1];
		end

		tks_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_entry  (new_entry),
			.left_entry (left_w),
			.right_entry(right_w),
			.occupied   (CW'(i) < held),
			.ge_left    (ge_left_w),
			.ge         (ge[i]),
			.entry      (ents[i])
		);
	end

	assign head   = ents[0];
	assign all_ge = &ge;

	// ge is a thermometer: the insert rank is where it drops to zero
	always_comb begin
		pos = '0;
		for (int i = 1; i < MAX_KEEP; i++) begin
			if (ge[i-1] && !ge[i]) pos = pos | IW'(i);
		end
	end

	// full list and the candidate ranks behind every held entry
	assign reject = (held == keep) && (all_ge || (CW'({1'b0, pos}) == held));

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ranked list block: drives insert, dump and clear
// beats with bursty input and a stalling receiver, and checks every result beat
// against a scoreboard that keeps its own sorted copy of the held list.
// ----------------------------------------------------------------------------
module tb;

	import tks_pkg::*;

	localparam int CAP        = MAX_KEEP_DEF;
	localparam int IDLE_LIMIT = 2000;
	localparam int MAX_REPORT = 10;

	// one held entry of the predicted list
	typedef struct {
		bit [15:0] node_a;
		bit [15:0] node_b;
		int        score;
	} ranked_pair_t;

	// one expected result beat
	typedef struct {
		kind_t     kind;
		bit        accepted;
		bit [3:0]  position;
		bit        entry_valid;
		bit [15:0] node_a;
		bit [15:0] node_b;
		int        score;
		bit        last;
	} rank_beat_t;

	// ------------------------------------------------------------------------
	// Scoreboard: sorted-list predictor and queue of expected result beats
	// ------------------------------------------------------------------------
	class rank_scoreboard;
		ranked_pair_t list[CAP];
		int           held;
		int           keep_reg;
		rank_beat_t   expected_beats[$];
		int           errors;

		function new();
			held     = 0;
			keep_reg = 16;
			errors   = 0;
		endfunction

		function int clamp_keep();
			if (keep_reg < 1)
				return 1;
			if (keep_reg > CAP)
				return CAP;
			return keep_reg;
		endfunction

		function void set_keep(bit [4:0] v);
			keep_reg = v;
			if (held > clamp_keep())
				held = clamp_keep();
		endfunction

		function void push_beat(kind_t kind, bit acc, int pos, bit valid,
				ranked_pair_t e, bit last);
			rank_beat_t r;
			r.kind        = kind;
			r.accepted    = acc;
			r.position    = pos[3:0];
			r.entry_valid = valid;
			r.node_a      = e.node_a;
			r.node_b      = e.node_b;
			r.score       = e.score;
			r.last        = last;
			expected_beats.push_back(r);
		endfunction

		// work out the result beats of one accepted command
		function void note_command(bit [1:0] op, bit [15:0] a, bit [15:0] b, int s);
			ranked_pair_t blank;
			ranked_pair_t cand;
			int k, len, pos, j;
			blank.node_a = '0;
			blank.node_b = '0;
			blank.score  = 0;
			cand.node_a  = a;
			cand.node_b  = b;
			cand.score   = s;
			case (op)
				OP_INSERT: begin
					k   = clamp_keep();
					len = (held > k) ? k : held;
					if (len == k && len > 0 && s <= list[len-1].score) begin
						// full and no better than the tail: dropped
						held = len;
						push_beat(KIND_INSERT, 1'b0, 0, 1'b0, blank, 1'b1);
					end else begin
						pos = 0;
						while (pos < len && s <= list[pos].score)
							pos++;
						j = (len < k) ? len : k - 1;
						while (j > pos) begin
							list[j] = list[j-1];
							j--;
						end
						list[pos] = cand;
						if (len < k)
							len++;
						held = len;
						push_beat(KIND_INSERT, 1'b1, pos, 1'b0, blank, 1'b1);
					end
				end
				OP_DUMP: begin
					if (held == 0)
						push_beat(KIND_ENTRY, 1'b0, 0, 1'b0, blank, 1'b1);
					for (int i = 0; i < held; i++)
						push_beat(KIND_ENTRY, 1'b0, i, 1'b1, list[i], i + 1 == held);
				end
				OP_CLEAR: begin
					held = 0;
					push_beat(KIND_CLEAR, 1'b0, 0, 1'b0, blank, 1'b1);
				end
				default: ;
			endcase
		endfunction

		// compare one taken result beat with the oldest expectation
		function void check_beat(logic [1:0] kind, logic acc, logic [3:0] pos,
				logic valid, logic [15:0] a, logic [15:0] b, logic [31:0] s,
				logic last);
			rank_beat_t e;
			if (expected_beats.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORT)
					$display("%0t: unexpected result beat kind=%0d pos=%0d", $realtime,
						kind, pos);
				return;
			end
			e = expected_beats.pop_front();
			if (kind !== e.kind || acc !== e.accepted || pos !== e.position ||
					valid !== e.entry_valid || a !== e.node_a || b !== e.node_b ||
					s !== e.score || last !== e.last) begin
				errors++;
				if (errors <= MAX_REPORT) begin
					$display("%0t: result mismatch", $realtime);
					$display("  exp kind=%0d acc=%0d pos=%0d valid=%0d a=%h b=%h s=%h last=%0d",
						e.kind, e.accepted, e.position, e.entry_valid, e.node_a,
						e.node_b, e.score, e.last);
					$display("  got kind=%0d acc=%0d pos=%0d valid=%0d a=%h b=%h s=%h last=%0d",
						kind, acc, pos, valid, a, b, s, last);
				end
			end
		endfunction

		function int pending();
			return expected_beats.size();
		endfunction

		// leftover expectations count as failures
		function int final_errors();
			if (expected_beats.size() != 0) begin
				errors += expected_beats.size();
				$display("%0d result beats never arrived", expected_beats.size());
			end
			return errors;
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT signals
	// ------------------------------------------------------------------------
	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [KEEP_W-1:0]     cfg_wdata     = '0;
	logic                  s_tvalid      = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata       = '0;
	logic [1:0]            s_tuser       = '0;
	logic                  m_tvalid;
	logic                  m_tready      = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	rank_scoreboard sb = new();
	int             burst_left = 0;
	int             idle_cycles = 0;
	int unsigned    ready_cyc = 0;

	top_k_sorted_insert u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.m_axis_tlast  (m_tlast)
	);

	// clock, 8 ns period
	initial begin
		forever #4 clk = ~clk;
	end

	// receiver stall pattern: steps through four ready modes picked by a free-running counter
	always @(posedge clk) begin
		ready_cyc <= ready_cyc + 1;
		case ((ready_cyc >> 7) & 3)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 99) < 70);
			2: m_tready <= ((ready_cyc % 3) == 0);
			default: m_tready <= ($urandom_range(0, 99) < 30);
		endcase
	end

	// result beat checking
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_beat(m_tuser, m_tdata[0], m_tdata[4:1], m_tdata[5], m_tdata[21:6],
				m_tdata[37:22], m_tdata[69:38], m_tlast);
	end

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	// send one command beat, with random gaps between bursts
	task automatic send_cmd(bit [1:0] op, bit [15:0] a, bit [15:0] b, bit [31:0] s);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {s, b, a};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		sb.note_command(op, a, b, s);
	endtask

	// wait for the list to go quiet, then write keep_count
	task automatic write_keep(bit [4:0] v);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		// an ignored command may still be in flight
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_keep(v);
	endtask

	function automatic bit [31:0] rand_score();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 40)
			return {16'($urandom_range(0, 4) - 2), 16'h0} + 32'($urandom_range(0, 1) << 15);
		if (sel < 80)
			return $urandom;
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return 32'h0000_0001;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		bit [4:0] keep_plan[8];
		int       counted;
		int       pick;
		bit [1:0] op;

		keep_plan = '{5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd0, 5'd8, 5'd16};
		keep_plan[5] = 5'($urandom_range(1, 16));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list, extremes, ties, ignored op
		send_cmd(OP_DUMP, 16'h0, 16'h0, 32'h0);
		send_cmd(OP_INSERT, 16'hFFFF, 16'h0000, 32'h7FFF_FFFF);
		send_cmd(OP_INSERT, 16'h0000, 16'hFFFF, 32'h8000_0000);
		send_cmd(OP_INSERT, 16'h1111, 16'h2222, 32'h0);
		send_cmd(OP_INSERT, 16'h3333, 16'h4444, 32'h0);
		send_cmd(OP_INSERT, 16'h5555, 16'h6666, 32'h7FFF_FFFF);
		send_cmd(OP_DUMP, 16'h0, 16'h0, 32'h0);
		send_cmd(2'd3, 16'hABCD, 16'h1234, 32'h1);
		send_cmd(OP_CLEAR, 16'h0, 16'h0, 32'h0);
		send_cmd(OP_DUMP, 16'h0, 16'h0, 32'h0);

		// small keep: tail drop, equal-to-tail rejection
		write_keep(5'd2);
		send_cmd(OP_INSERT, 16'h0001, 16'h0001, 32'h0005_0000);
		send_cmd(OP_INSERT, 16'h0002, 16'h0002, 32'h0007_0000);
		send_cmd(OP_INSERT, 16'h0003, 16'h0003, 32'h0005_0000);
		send_cmd(OP_INSERT, 16'h0004, 16'h0004, 32'h0006_0000);
		send_cmd(OP_INSERT, 16'h0005, 16'h0005, 32'h8000_0000);
		send_cmd(OP_DUMP, 16'h0, 16'h0, 32'h0);

		// keep of zero acts as one and cuts the list
		write_keep(5'd0);
		send_cmd(OP_DUMP, 16'h0, 16'h0, 32'h0);
		send_cmd(OP_INSERT, 16'hBEEF, 16'hCAFE, 32'h0008_0000);
		send_cmd(OP_DUMP, 16'h0, 16'h0, 32'h0);

		// random phases over several keep settings
		foreach (keep_plan[p]) begin
			write_keep(keep_plan[p]);
			counted = 0;
			while (counted < 30) begin
				pick = $urandom_range(0, 99);
				if (pick < 74)
					op = OP_INSERT;
				else if (pick < 88)
					op = OP_DUMP;
				else if (pick < 94)
					op = OP_CLEAR;
				else
					op = 2'd3;
				send_cmd(op, 16'($urandom), 16'($urandom), rand_score());
				if (op != 2'd3)
					counted++;
			end
			// every phase ends by reading out what is held
			send_cmd(OP_DUMP, 16'($urandom), 16'($urandom), $urandom);
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (sb.final_errors() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
